>>> hw/rtl/bbt_pkg.sv
package bbt_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);       // column index
    localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;  // row count, holds MAX_HEIGHT
    localparam int WCFG_W = 11;
    localparam int HCFG_W = 13;
    localparam int EFFW_W = COL_W + 1;                // effective width, holds MAX_WIDTH
    localparam int RING_W = 2;                        // four rows in the line store
    localparam int ADDR_W = RING_W + COL_W;
    localparam int SUM_W  = 12;                       // 9 * 255 fits
    localparam int CNT_W  = 4;
    localparam int STEP_W = 4;
    localparam int PIX_W  = 24;
    localparam int IDX_W  = 8;
    localparam int CDAT_W = 13;

    localparam logic [STEP_W-1:0] LAST_TAP  = 4'd9;   // drain step after nine taps
    localparam logic [STEP_W-1:0] LAST_DIV  = 4'd11;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [IDX_W-1:0] CFG_WIDTH  = 8'd0;
    localparam logic [IDX_W-1:0] CFG_HEIGHT = 8'd1;

    typedef struct packed {
        logic wr_pix;
        logic start_sum;
        logic sum_step;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic rdy;
        logic sum_done;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

>>> hw/rtl/bbt_pix_if.sv
interface bbt_pix_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, operation, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

>>> hw/rtl/bbt_res_if.sv
interface bbt_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

>>> hw/rtl/bbt_cfg_if.sv
interface bbt_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/bbt_ctrl.sv
module bbt_ctrl
    import bbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_op,
    output logic o_in_ready,
    output logic o_cfg_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_READ  = 5'b00100,
        S_DIV   = 5'b01000,
        S_PUSH  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   w_in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.wr_pix    = w_in_acc && (i_in_op == OP_PIXEL);
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.rdy) begin
                    n_state = S_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.start_sum = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_READ: begin
                o_cmd.sum_step = 1'b1;
                if (i_sts.sum_done) n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    a_acc_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_CHECK)) else $error("accept not followed by check");
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_sum |-> !i_sts.out_busy) else $error("sum started with output full");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy) else $error("result overwritten");

endmodule

>>> hw/rtl/bbt_dp.sv
module bbt_dp
    import bbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [23:0] i_pix,
    input  logic        i_cfg_wr,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CDAT_W-1:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_out_pix,
    output logic        o_frame_end
);

    logic [WCFG_W-1:0] r_wcfg;
    logic [HCFG_W-1:0] r_hcfg;
    logic [EFFW_W-1:0] w_w;
    logic [ROW_W-1:0]  w_h;

    logic [COL_W-1:0]   r_in_col, r_out_col;
    logic [ROW_W-1:0]   r_in_row;
    logic [ROW_W-2:0]   r_out_row;

    logic [PIX_W-1:0]   r_mem [0:(1<<ADDR_W)-1];
    logic [PIX_W-1:0]   r_rd;
    logic               r_rd_vld;

    logic [STEP_W-1:0]  r_step;
    logic [CNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]   r_acc [3];
    logic [CNT_W-1:0]   r_rem [3];

    logic               r_out_valid, r_frame_end;
    logic [PIX_W-1:0]   r_out_pix;

    logic [ROW_W-1:0]   w_need_r, w_rr;
    logic [EFFW_W-1:0]  w_need_c, w_cc;
    logic [1:0]         w_dr, w_dc;
    logic               w_tap_ok, w_last, w_in_ok, w_in_wrap, w_restart;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [ROW_W-1:0]   w_row_idx;
    logic [EFFW_W-1:0]  w_col_idx;

    // effective frame size
    always_comb begin
        if (r_wcfg == '0)                  w_w = EFFW_W'(1);
        else if (r_wcfg > WCFG_W'(MAX_WIDTH)) w_w = EFFW_W'(MAX_WIDTH);
        else                               w_w = EFFW_W'(r_wcfg);
        if (r_hcfg == '0)                  w_h = ROW_W'(1);
        else if (r_hcfg > HCFG_W'(MAX_HEIGHT)) w_h = ROW_W'(MAX_HEIGHT);
        else                               w_h = ROW_W'(r_hcfg);
    end

    assign w_in_ok   = (r_in_row < w_h) && (EFFW_W'(r_in_col) < w_w);
    assign w_in_wrap = (EFFW_W'(r_in_col) + EFFW_W'(1)) >= w_w;

    // readiness of the next output
    assign w_need_r = (ROW_W'(r_out_row) + ROW_W'(1) < w_h) ? ROW_W'(r_out_row) + ROW_W'(1)
                                                           : w_h - ROW_W'(1);
    assign w_need_c = (EFFW_W'(r_out_col) + EFFW_W'(1) < w_w) ?
                      EFFW_W'(r_out_col) + EFFW_W'(1) : w_w - EFFW_W'(1);
    assign o_sts.rdy = (ROW_W'(r_out_row) < w_h) && (EFFW_W'(r_out_col) < w_w) &&
                       ((r_in_row > w_need_r) ||
                        ((r_in_row == w_need_r) && (EFFW_W'(r_in_col) > w_need_c)));
    assign w_last = (ROW_W'(r_out_row) == w_h - ROW_W'(1)) &&
                    (EFFW_W'(r_out_col) == w_w - EFFW_W'(1));

    // tap position: offsets are stored +1 so that -1 needs no sign
    always_comb begin
        case (r_step)
            4'd0, 4'd1, 4'd2: w_dr = 2'd0;
            4'd3, 4'd4, 4'd5: w_dr = 2'd1;
            default:          w_dr = 2'd2;
        endcase
        case (r_step)
            4'd0, 4'd3, 4'd6: w_dc = 2'd0;
            4'd1, 4'd4, 4'd7: w_dc = 2'd1;
            default:          w_dc = 2'd2;
        endcase
    end
    assign w_rr      = ROW_W'(r_out_row) + ROW_W'(w_dr);
    assign w_cc      = EFFW_W'(r_out_col) + EFFW_W'(w_dc);
    assign w_tap_ok  = (r_step < LAST_TAP) && (w_rr != '0) && (w_rr <= w_h) &&
                       (w_cc != '0) && (w_cc <= w_w);
    assign w_row_idx = w_rr - ROW_W'(1);
    assign w_col_idx = w_cc - EFFW_W'(1);
    assign w_rd_addr = {w_row_idx[RING_W-1:0], w_col_idx[COL_W-1:0]};

    assign o_sts.sum_done = (r_step == LAST_TAP);
    assign o_sts.div_done = (r_step == LAST_DIV);
    assign o_sts.out_busy = r_out_valid;

    // line store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pix && w_in_ok)
            r_mem[{r_in_row[RING_W-1:0], r_in_col}] <= i_pix;
        r_rd <= r_mem[w_rd_addr];
    end

    assign w_restart = i_cfg_wr &&
                       ((i_cfg_index == CFG_WIDTH) || (i_cfg_index == CFG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcfg      <= WCFG_W'(640);
            r_hcfg      <= HCFG_W'(480);
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (i_cfg_wr && (i_cfg_index == CFG_WIDTH))  r_wcfg <= i_cfg_data[WCFG_W-1:0];
            if (i_cfg_wr && (i_cfg_index == CFG_HEIGHT)) r_hcfg <= i_cfg_data;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            r_rd_vld <= i_cmd.sum_step && w_tap_ok;

            if (w_restart) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (i_cmd.wr_pix && w_in_ok) begin
                    if (w_in_wrap) begin
                        r_in_col <= '0;
                        r_in_row <= r_in_row + ROW_W'(1);
                    end else begin
                        r_in_col <= r_in_col + COL_W'(1);
                    end
                end
                if (i_cmd.emit) begin
                    r_out_valid <= 1'b1;
                    if (w_last) begin
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_col <= '0;
                        r_out_row <= '0;
                    end else if (EFFW_W'(r_out_col) + EFFW_W'(1) >= w_w) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + (ROW_W-1)'(1);
                    end else begin
                        r_out_col <= r_out_col + COL_W'(1);
                    end
                end
            end

            if (i_cmd.start_sum)                      r_step <= '0;
            else if (i_cmd.sum_step && o_sts.sum_done) r_step <= '0;
            else if (i_cmd.sum_step || i_cmd.div_step) r_step <= r_step + STEP_W'(1);
        end
    end

    // sum of taps, then restoring division in place on the accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_sum) r_cnt <= '0;
        else if (i_cmd.sum_step && w_tap_ok) r_cnt <= r_cnt + CNT_W'(1);
    end

    for (genvar k = 0; k < 3; k++) begin : g_ch
        logic [CNT_W:0] w_trial;
        logic           w_ge;
        assign w_trial = {r_rem[k], r_acc[k][SUM_W-1]};
        assign w_ge    = w_trial >= {1'b0, r_cnt};
        always_ff @(posedge i_clk) begin
            if (i_cmd.start_sum) begin
                r_acc[k] <= '0;
                r_rem[k] <= '0;
            end else if (i_cmd.sum_step && r_rd_vld) begin
                r_acc[k] <= r_acc[k] + SUM_W'(r_rd[8*k +: 8]);
            end else if (i_cmd.div_step) begin
                r_acc[k] <= {r_acc[k][SUM_W-2:0], w_ge};
                r_rem[k] <= w_ge ? CNT_W'(w_trial - {1'b0, r_cnt}) : w_trial[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_pix   <= {r_acc[2][7:0], r_acc[1][7:0], r_acc[0][7:0]};
            r_frame_end <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pix   = r_out_pix;
    assign o_frame_end = r_frame_end;

endmodule

>>> hw/rtl/box_blur_three_by_three.sv
// 3x3 box blur on an RGB raster stream.
// Channels: i_pix takes pixels in raster order (operation 0) or flush ticks
// (operation 1); o_res gives blurred pixels in raster order, frame_end on the
// last pixel of a frame; i_cfg writes image_width (index 0) and image_height
// (index 1), which restarts the frame. Write configuration only when idle.
// Each output is the truncated mean of the in-frame part of its 3x3
// neighbourhood, taken from a four-row line store in block RAM.
// Timing: one transfer in at a time. An item that releases no result only
// passes the check state; one that releases a result then reads its taps
// through the single RAM read port, runs the per-channel restoring dividers
// and loads the output register, with the result valid the cycle after.
// Outputs trail inputs by one row plus one pixel; flush ticks drain the
// last row. Reset: 640x480, all positions at zero, output empty; the line
// store is not cleared. A stalled receiver holds the output register; the
// next item is still taken, but no new sum starts until the result leaves.
module box_blur_three_by_three
    import bbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bbt_pix_if.sink   i_pix,
    bbt_res_if.source o_res,
    bbt_cfg_if.sink   i_cfg
);

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_in_ready, w_cfg_ready;
    logic [23:0] w_out_pix;

    assign i_pix.ready = w_in_ready;
    assign i_cfg.ready = w_cfg_ready;

    bbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_in_op     (i_pix.operation),
        .o_in_ready  (w_in_ready),
        .o_cfg_ready (w_cfg_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bbt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_pix       ({i_pix.blue_in, i_pix.green_in, i_pix.red_in}),
        .i_cfg_wr    (i_cfg.valid && w_cfg_ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_out_pix   (w_out_pix),
        .o_frame_end (o_res.frame_end)
    );

    // colour lanes: red low, blue high
    assign o_res.red_out   = w_out_pix[7:0];
    assign o_res.green_out = w_out_pix[15:8];
    assign o_res.blue_out  = w_out_pix[23:16];

endmodule

>>> sim/bbt_blur_scoreboard.sv
`timescale 1ns / 100ps

module bbt_blur_scoreboard
    import bbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bbt_pix_if   pix,
    bbt_res_if   res,
    bbt_cfg_if   cfg,
    output int   o_errors,
    output int   o_pending,
    output logic o_frame_idle,
    output int   o_results
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } blur_px_t;

    blur_px_t        blurred_q[$];
    logic [PIX_W-1:0] rows[4][MAX_WIDTH];
    logic [WCFG_W-1:0] width_reg;
    logic [HCFG_W-1:0] height_reg;
    int unsigned in_col, in_row, out_col, out_row;
    int errors, results;

    assign o_errors     = errors;
    assign o_pending    = blurred_q.size();
    assign o_frame_idle = (in_col == 0) && (in_row == 0) && (out_col == 0) && (out_row == 0);
    assign o_results    = results;

    function automatic int unsigned frame_w();
        int unsigned w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned frame_h();
        int unsigned h;
        h = height_reg;
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    task automatic restart();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endtask

    // one accepted item: store the pixel, then release at most one blurred pixel
    task automatic blur_step(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned w, h, need_r, need_c, sr, sg, sb, cnt;
        int rr, cc;
        blur_px_t px;
        logic [PIX_W-1:0] tap;
        w = frame_w();
        h = frame_h();
        if (op == OP_PIXEL && in_row < h && in_col < w) begin
            rows[in_row % 4][in_col] = {r, g, b};
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        if (out_row >= h || out_col >= w) return;
        need_r = (out_row + 1 < h) ? out_row + 1 : h - 1;
        need_c = (out_col + 1 < w) ? out_col + 1 : w - 1;
        if (!(in_row > need_r || (in_row == need_r && in_col > need_c))) return;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (rr = int'(out_row) - 1; rr <= int'(out_row) + 1; rr++) begin
            for (cc = int'(out_col) - 1; cc <= int'(out_col) + 1; cc++) begin
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
                    tap = rows[rr % 4][cc];
                    sr += tap[23:16];
                    sg += tap[15:8];
                    sb += tap[7:0];
                    cnt++;
                end
            end
        end
        px.red       = 8'(sr / cnt);
        px.green     = 8'(sg / cnt);
        px.blue      = 8'(sb / cnt);
        px.frame_end = (out_row == h - 1) && (out_col == w - 1);
        blurred_q.push_back(px);
        if (px.frame_end) begin
            restart();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    initial begin
        foreach (rows[i, j]) rows[i][j] = '0;
    end

    always @(posedge i_clk) begin
        blur_px_t want;
        if (!i_rst_n) begin
            width_reg  = 11'd640;
            height_reg = 13'd480;
            restart();
            blurred_q.delete();
            errors  = 0;
            results = 0;
        end else begin
            if (res.valid && res.ready) begin
                results++;
                if (blurred_q.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    want = blurred_q.pop_front();
                    if (res.red_out !== want.red) begin
                        $error("red_out: expected %0d, got %0d", want.red, res.red_out);
                        errors++;
                    end
                    if (res.green_out !== want.green) begin
                        $error("green_out: expected %0d, got %0d", want.green, res.green_out);
                        errors++;
                    end
                    if (res.blue_out !== want.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.blue, res.blue_out);
                        errors++;
                    end
                    if (res.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0d, got %0d", want.frame_end,
                               res.frame_end);
                        errors++;
                    end
                end
            end
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == CFG_WIDTH) begin
                    width_reg = cfg.data[WCFG_W-1:0];
                    restart();
                end else if (cfg.index == CFG_HEIGHT) begin
                    height_reg = cfg.data[HCFG_W-1:0];
                    restart();
                end
            end
            if (pix.valid && pix.ready)
                blur_step(pix.operation, pix.red_in, pix.green_in, pix.blue_in);
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import bbt_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_WAIT  = 60;     // extra wait once nothing is owed and the frame is idle

    logic i_clk;
    logic i_rst_n;

    bbt_pix_if pix ();
    bbt_res_if res ();
    bbt_cfg_if cfg ();

    int errors, pending, results;
    logic frame_idle;
    int cycles;
    int pixels_sent, flushes_sent, frames_run;
    bit burst;           // no sender gaps while set

    box_blur_three_by_three u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    bbt_blur_scoreboard u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pix          (pix),
        .res          (res),
        .cfg          (cfg),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_frame_idle (frame_idle),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(3, 1);
        if (p < 98) return $urandom_range(15, 4);
        return $urandom_range(80, 20);
    endfunction

    // receiver: random back-pressure, plus one long hold-off so the block fills
    initial begin : sink_side
        int hold;
        int gap;
        bit held_once;
        hold = 0;
        held_once = 0;
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_once && cycles > 4000) begin
                held_once = 1;
                hold = 600;
            end
            if (hold > 0) begin
                res.ready <= 1'b0;
                hold--;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    res.ready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                    @(negedge i_clk);
                end
                res.ready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic push_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix.valid     <= 1'b1;
        pix.operation <= op;
        pix.red_in    <= r;
        pix.green_in  <= g;
        pix.blue_in   <= b;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (op == OP_PIXEL) pixels_sent++;
        else flushes_sent++;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CDAT_W-1:0] value);
        pix.valid <= 1'b0;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // block idle: nothing owed, frame counters at zero, pipeline settled
    task automatic settle();
        pix.valid <= 1'b0;
        while (pending != 0 || !frame_idle) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    function automatic logic [7:0] colour();
        int p;
        p = $urandom_range(9);
        if (p == 0) return 8'd0;
        if (p == 1) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    // one frame: pixels, with flush ticks mixed in when noisy, then flush until drained
    task automatic run_frame(logic [CDAT_W-1:0] w_val, logic [CDAT_W-1:0] h_val,
                             int n_pixels, bit noisy, bit pause_mid);
        int k;
        settle();
        write_reg(CFG_WIDTH, w_val);
        write_reg(CFG_HEIGHT, h_val);
        frames_run++;
        for (k = 0; k < n_pixels; k++) begin
            if (noisy && $urandom_range(9) == 0)
                push_item(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
            if (pause_mid && k == n_pixels / 2) begin
                // sender waits until every result owed so far has arrived
                pix.valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            push_item(OP_PIXEL, colour(), colour(), colour());
        end
        // stray pixels after the frame is in are dropped while outputs wait
        if (noisy && !frame_idle && $urandom_range(3) == 0)
            push_item(OP_PIXEL, colour(), colour(), colour());
        while (!frame_idle)
            push_item(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // frame cut short: some pixels, wait for what they release, then restart
    task automatic run_partial(logic [CDAT_W-1:0] w_val, logic [CDAT_W-1:0] h_val,
                               int n_pixels);
        int k;
        settle();
        write_reg(CFG_WIDTH, w_val);
        write_reg(CFG_HEIGHT, h_val);
        frames_run++;
        for (k = 0; k < n_pixels; k++)
            push_item(OP_PIXEL, colour(), colour(), colour());
        push_item(OP_FLUSH, 8'hA5, 8'h5A, 8'hC3);
        pix.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        write_reg(CFG_WIDTH, w_val);
    endtask

    initial begin : source_side
        int w, h;
        i_rst_n       = 1'b0;
        pix.valid     = 1'b0;
        pix.operation = OP_PIXEL;
        pix.red_in    = '0;
        pix.green_in  = '0;
        pix.blue_in   = '0;
        cfg.valid     = 1'b0;
        cfg.index     = CFG_WIDTH;
        cfg.data      = '0;
        cycles = 0;
        pixels_sent = 0; flushes_sent = 0; frames_run = 0;
        burst = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // flush on a fresh frame: nothing ready, no result
        write_reg(CFG_WIDTH, 13'd1);
        write_reg(CFG_HEIGHT, 13'd1);
        push_item(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);

        // directed: single pixel, zero registers acting as one, a 3x3 frame
        run_frame(13'd1, 13'd1, 1, 0, 0);
        run_frame(13'd0, 13'd0, 1, 0, 0);
        run_frame(13'd3, 13'd3, 9, 0, 1);
        // width with bits above its field set (masked to 2), unknown index ignored
        settle();
        write_reg(8'hFF, 13'h1FFF);
        run_frame(13'h1802, 13'd2, 4, 0, 0);
        run_frame(13'd3, 13'd1, 3, 0, 0);
        run_frame(13'd1, 13'd3, 3, 0, 0);

        // random frames, mostly small
        while (pixels_sent < 450) begin
            w = $urandom_range(8, 1);
            h = $urandom_range(6, 1);
            burst = ($urandom_range(4) == 0);
            run_frame(w[CDAT_W-1:0], h[CDAT_W-1:0], w * h, 1, $urandom_range(7) == 0);
        end
        burst = 0;

        // values at and above the limits, frames left unfinished and then restarted
        run_partial(13'd2047, 13'd1, 60);
        run_partial(13'd1, 13'd8191, 60);
        run_partial(13'd4, 13'd4096, 8);
        settle();

        $display("%0d frames, %0d pixels and %0d flush ticks sent, %0d blurred pixels checked",
                 frames_run, pixels_sent, flushes_sent, results);
        $display("whole frames up to 8x6, cut-short frames with oversized settings, stalls");
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> box_blur_three_by_three.f
hw/rtl/bbt_pkg.sv
hw/rtl/bbt_pix_if.sv
hw/rtl/bbt_res_if.sv
hw/rtl/bbt_cfg_if.sv
hw/rtl/bbt_ctrl.sv
hw/rtl/bbt_dp.sv
hw/rtl/box_blur_three_by_three.sv
sim/bbt_blur_scoreboard.sv
sim/tb.sv
